@@ rtl/tsd_pkg.sv @@
`timescale 1ns / 1ps

package tsd_pkg;

  localparam int CoordW    = 12;
  localparam int SizeW     = 13;
  localparam int TravelW   = 12;
  localparam int RatioW    = 4;
  localparam int TimeW     = 32;
  localparam int MaxTimeW  = 16;
  localparam int ByteW     = 8;
  localparam int CountW    = 4;
  localparam int SwipeW    = 2;
  localparam int ProdW     = TravelW + RatioW;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_PANEL_WIDTH      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PANEL_HEIGHT     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SWIPE_MIN_TRAVEL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TRAVEL_RATIO     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SWIPE_MAX_TIME   = 3'd4;

  localparam logic [SizeW-1:0]    PANEL_WIDTH_RST      = 13'd368;
  localparam logic [SizeW-1:0]    PANEL_HEIGHT_RST     = 13'd448;
  localparam logic [TravelW-1:0]  SWIPE_MIN_TRAVEL_RST = 12'd90;
  localparam logic [RatioW-1:0]   TRAVEL_RATIO_RST     = 4'd2;
  localparam logic [MaxTimeW-1:0] SWIPE_MAX_TIME_RST   = 16'd700;

  localparam logic [SwipeW-1:0] SWIPE_NONE  = 2'd0;
  localparam logic [SwipeW-1:0] SWIPE_LEFT  = 2'd1;
  localparam logic [SwipeW-1:0] SWIPE_RIGHT = 2'd2;

  localparam logic MODE_POLL = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic               read_ok;
    logic [ByteW-1:0]   status_byte;
    logic [ByteW-1:0]   x_high_byte;
    logic [ByteW-1:0]   x_low_byte;
    logic [ByteW-1:0]   y_high_byte;
    logic [ByteW-1:0]   y_low_byte;
    logic [TimeW-1:0]   now_ms;
  } tsd_item_t;

  typedef struct packed {
    logic               touch_down;
    logic [CoordW-1:0]  point_x;
    logic [CoordW-1:0]  point_y;
    logic               cancel_touch;
    logic [SwipeW-1:0]  taken_swipe;
  } tsd_result_t;

  typedef struct packed {
    logic [SizeW-1:0]    panel_width;
    logic [SizeW-1:0]    panel_height;
    logic [TravelW-1:0]  swipe_min_travel;
    logic [RatioW-1:0]   travel_ratio;
    logic [MaxTimeW-1:0] swipe_max_time;
  } tsd_cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] last_x;
    logic [CoordW-1:0] last_y;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [TimeW-1:0]  start_time;
    logic              tracking;
    logic              swallowed;
    logic [SwipeW-1:0] pending_swipe;
  } tsd_state_t;

  // a size of zero acts as one; a size above the coordinate range never clamps
  function automatic logic [CoordW-1:0] clamp_axis(input logic [CoordW-1:0] v,
                                                   input logic [SizeW-1:0] size);
    logic [SizeW-1:0]  s;
    logic [SizeW-1:0]  s_m1;
    logic [CoordW-1:0] r;
    s    = (size == '0) ? SizeW'(1) : size;
    s_m1 = s - SizeW'(1);
    r    = v;
    if ({1'b0, v} >= s) begin
      r = s_m1[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/tsd_in_if.sv @@
`timescale 1ns / 1ps

interface tsd_in_if import tsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic               read_ok;
  logic [ByteW-1:0]   status_byte;
  logic [ByteW-1:0]   x_high_byte;
  logic [ByteW-1:0]   x_low_byte;
  logic [ByteW-1:0]   y_high_byte;
  logic [ByteW-1:0]   y_low_byte;
  logic [TimeW-1:0]   now_ms;

  modport source (
    output valid, mode, read_ok, status_byte, x_high_byte, x_low_byte,
           y_high_byte, y_low_byte, now_ms,
    input  ready
  );

  modport sink (
    input  valid, mode, read_ok, status_byte, x_high_byte, x_low_byte,
           y_high_byte, y_low_byte, now_ms,
    output ready
  );
endinterface

@@ rtl/tsd_out_if.sv @@
`timescale 1ns / 1ps

interface tsd_out_if import tsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              touch_down;
  logic [CoordW-1:0] point_x;
  logic [CoordW-1:0] point_y;
  logic              cancel_touch;
  logic [SwipeW-1:0] taken_swipe;

  modport source (
    output valid, touch_down, point_x, point_y, cancel_touch, taken_swipe,
    input  ready
  );

  modport sink (
    input  valid, touch_down, point_x, point_y, cancel_touch, taken_swipe,
    output ready
  );
endinterface

@@ rtl/tsd_step.sv @@
`timescale 1ns / 1ps

module tsd_step import tsd_pkg::*; (
  input  tsd_item_t   item,
  input  tsd_state_t  state,
  input  tsd_cfg_t    cfg,
  output tsd_result_t res,
  output tsd_state_t  state_nxt
);

  logic [CoordW-1:0] x;
  logic [CoordW-1:0] y;
  logic [CoordW-1:0] adx;
  logic [CoordW-1:0] ady;
  logic [ProdW-1:0]  ady_scaled;
  logic [TimeW-1:0]  elapsed;
  logic              pressed;
  logic              swipe_hit;

  assign x = clamp_axis({item.x_high_byte[CountW-1:0], item.x_low_byte}, cfg.panel_width);
  assign y = clamp_axis({item.y_high_byte[CountW-1:0], item.y_low_byte}, cfg.panel_height);

  assign adx = (x >= state.start_x) ? (x - state.start_x) : (state.start_x - x);
  assign ady = (y >= state.start_y) ? (y - state.start_y) : (state.start_y - y);
  assign ady_scaled = ProdW'(ady) * ProdW'(cfg.travel_ratio);
  // modulo 2^32 elapsed time
  assign elapsed = item.now_ms - state.start_time;

  assign pressed = item.read_ok && (item.status_byte[CountW-1:0] != '0);

  assign swipe_hit = (adx >= cfg.swipe_min_travel)
                  && (ProdW'(adx) > ady_scaled)
                  && (elapsed <= TimeW'(cfg.swipe_max_time));

  always_comb begin
    res       = '0;
    state_nxt = state;
    case (item.mode)
      MODE_TAKE: begin
        res.taken_swipe         = state.pending_swipe;
        state_nxt.pending_swipe = SWIPE_NONE;
      end
      MODE_POLL: begin
        if (!pressed) begin
          state_nxt.tracking  = 1'b0;
          state_nxt.swallowed = 1'b0;
          res.point_x         = state.last_x;
          res.point_y         = state.last_y;
        end else begin
          state_nxt.last_x = x;
          state_nxt.last_y = y;
          res.point_x      = x;
          res.point_y      = y;
          if (!state.swallowed) begin
            if (!state.tracking) begin
              state_nxt.tracking   = 1'b1;
              state_nxt.start_x    = x;
              state_nxt.start_y    = y;
              state_nxt.start_time = item.now_ms;
              res.touch_down       = 1'b1;
            end else if (swipe_hit) begin
              state_nxt.pending_swipe = (x < state.start_x) ? SWIPE_LEFT : SWIPE_RIGHT;
              state_nxt.swallowed     = 1'b1;
              res.cancel_touch        = 1'b1;
            end else begin
              res.touch_down = 1'b1;
            end
          end
        end
      end
      default: begin
        res       = '0;
        state_nxt = state;
      end
    endcase
  end

endmodule

@@ rtl/touch_swipe_detector.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// in_if     in   valid/ready        mode, read_ok, status_byte, x/y bytes, now_ms
// out_if    out  valid/ready        touch_down, point_x, point_y, cancel_touch,
//                                   taken_swipe
// cfg_*     in   cfg_we (no ready)  cfg_index, cfg_wdata
//
// One item per cycle sustained while out_if.ready stays high. An accepted item
// passes through the input register, then the result register, with the
// decode, clamp and swipe compare between them; its result is valid on out_if
// from the result register. Touch state updates as an item enters the result
// register. out_if.ready low holds the result and backs up into the input
// register; in_if.ready drops only when both are full.
// rst_n (synchronous) clears touch state, pending swipe and valid flags and
// loads the register defaults.

module touch_swipe_detector import tsd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  tsd_in_if.sink              in_if,
  tsd_out_if.source           out_if,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  tsd_cfg_t    cfg_r;
  tsd_state_t  state_r;
  tsd_state_t  state_nxt;
  tsd_item_t   in_item;
  tsd_item_t   s1_item_r;
  logic        s1_valid_r;
  tsd_result_t res_nxt;
  tsd_result_t out_res_r;
  logic        out_valid_r;
  logic        advance;
  logic        in_take;

  assign in_item = '{
    mode:        in_if.mode,
    read_ok:     in_if.read_ok,
    status_byte: in_if.status_byte,
    x_high_byte: in_if.x_high_byte,
    x_low_byte:  in_if.x_low_byte,
    y_high_byte: in_if.y_high_byte,
    y_low_byte:  in_if.y_low_byte,
    now_ms:      in_if.now_ms
  };

  // move the held item into the result register when that register frees up
  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign in_take     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.panel_width      <= PANEL_WIDTH_RST;
      cfg_r.panel_height     <= PANEL_HEIGHT_RST;
      cfg_r.swipe_min_travel <= SWIPE_MIN_TRAVEL_RST;
      cfg_r.travel_ratio     <= TRAVEL_RATIO_RST;
      cfg_r.swipe_max_time   <= SWIPE_MAX_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PANEL_WIDTH:      cfg_r.panel_width      <= cfg_wdata[SizeW-1:0];
        CFG_PANEL_HEIGHT:     cfg_r.panel_height     <= cfg_wdata[SizeW-1:0];
        CFG_SWIPE_MIN_TRAVEL: cfg_r.swipe_min_travel <= cfg_wdata[TravelW-1:0];
        CFG_TRAVEL_RATIO:     cfg_r.travel_ratio     <= cfg_wdata[RatioW-1:0];
        CFG_SWIPE_MAX_TIME:   cfg_r.swipe_max_time   <= cfg_wdata[MaxTimeW-1:0];
        default: ;
      endcase
    end
  end

  tsd_step u_step (
    .item      (s1_item_r),
    .state     (state_r),
    .cfg       (cfg_r),
    .res       (res_nxt),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.touch_down   = out_res_r.touch_down;
  assign out_if.point_x      = out_res_r.point_x;
  assign out_if.point_y      = out_res_r.point_y;
  assign out_if.cancel_touch = out_res_r.cancel_touch;
  assign out_if.taken_swipe  = out_res_r.taken_swipe;

endmodule
